// ----- hdl/scr_pkg.sv -----
// Shared types and constants for the sphere collision response pipeline.
// No dependencies; every other file in hdl/ refers to it by scoped names.
`default_nettype none

package scr_pkg;

   localparam int unsigned AXES       = 3;
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned CSR_W      = 16;
   localparam int unsigned FLAG_W     = 4;
   localparam int unsigned DIFF_W     = WORD_W + 1;
   localparam int unsigned FACTOR_W   = 17;
   localparam int unsigned KM_W       = FACTOR_W + WORD_W;
   localparam int unsigned NORM_STEPS = 5;
   localparam int unsigned ROOT_IN_W  = 2 * WORD_W;
   localparam int unsigned UNIT_FRAC  = 28;
   localparam int unsigned FACT_SHIFT = 13;
   localparam int unsigned NUM_W      = KM_W + FACT_SHIFT;
   localparam int unsigned DEN_W      = WORD_W + 1;
   localparam int unsigned QUO_W      = 30;
   localparam int unsigned UM_W       = UNIT_FRAC + 1;
   localparam int unsigned DIV_LANES  = AXES + 2;
   localparam int unsigned LANE_FA    = AXES;
   localparam int unsigned LANE_FB    = AXES + 1;
   localparam int unsigned PROD_W     = DIFF_W + UM_W + 1;
   localparam int unsigned DM_W       = PROD_W - 2;
   localparam int unsigned T_SHIFT    = 40;
   localparam int unsigned D_SHIFT    = 44;

   localparam int unsigned FLAG_OVL_A  = 0;
   localparam int unsigned FLAG_OVL_B  = 1;
   localparam int unsigned FLAG_TRIG_A = 2;
   localparam int unsigned FLAG_TRIG_B = 3;

   localparam logic [FACTOR_W-1:0] ONE_Q15           = FACTOR_W'(32768);
   localparam logic [CSR_W-1:0]    RESTITUTION_RESET = CSR_W'(32768);

   typedef struct packed {
      logic        [WORD_W-1:0] mass_a;
      logic        [WORD_W-1:0] mass_b;
      logic signed [WORD_W-1:0] vel_a_x;
      logic signed [WORD_W-1:0] vel_a_y;
      logic signed [WORD_W-1:0] vel_a_z;
      logic signed [WORD_W-1:0] vel_b_x;
      logic signed [WORD_W-1:0] vel_b_y;
      logic signed [WORD_W-1:0] vel_b_z;
      logic signed [WORD_W-1:0] offset_x;
      logic signed [WORD_W-1:0] offset_y;
      logic signed [WORD_W-1:0] offset_z;
      logic        [FLAG_W-1:0] pair_flags;
   } scr_req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] new_vel_a_x;
      logic signed [WORD_W-1:0] new_vel_a_y;
      logic signed [WORD_W-1:0] new_vel_a_z;
      logic signed [WORD_W-1:0] new_vel_b_x;
      logic signed [WORD_W-1:0] new_vel_b_y;
      logic signed [WORD_W-1:0] new_vel_b_z;
      logic                     responded;
      logic                     degenerate;
      logic                     notice_a_trigger;
      logic                     notice_b_trigger;
   } scr_rsp_type;

   typedef struct packed {
      logic [AXES-1:0][WORD_W-1:0] va;
      logic [AXES-1:0][WORD_W-1:0] vb;
      logic [AXES-1:0][DIFF_W-1:0] diff;
      logic [AXES-1:0]             cneg;
      logic                        apply;
      logic                        degen;
      logic                        notice_a;
      logic                        notice_b;
   } scr_base_type;

   typedef struct packed {
      scr_base_type                base;
      logic [AXES-1:0][WORD_W-1:0] cms;
      logic [DEN_W-1:0]            total;
      logic [KM_W-1:0]             km_a;
      logic [KM_W-1:0]             km_b;
   } scr_root_side_type;

endpackage

`default_nettype wire

// ----- hdl/scr_sqrt_pipe.sv -----
// Pipelined integer square root, one result bit per stage, with side data.
// Depends on scr_pkg for default widths.
`default_nettype none

module scr_sqrt_pipe #(
   parameter int unsigned IN_W   = scr_pkg::ROOT_IN_W,
   parameter int unsigned SIDE_W = 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire logic [IN_W-1:0]     in_radicand,
   input  wire logic [SIDE_W-1:0]   in_side,
   output logic                     out_valid,
   output logic [IN_W/2-1:0]        out_root,
   output logic [SIDE_W-1:0]        out_side
);

   localparam int unsigned STEPS = IN_W / 2;
   localparam logic [IN_W-1:0] ROOT_ONE = IN_W'(1);

   logic              valid_ff [STEPS];
   logic [IN_W-1:0]   rem_ff   [STEPS];
   logic [IN_W-1:0]   root_ff  [STEPS];
   logic [SIDE_W-1:0] side_ff  [STEPS];

   logic              src_valid [STEPS];
   logic [IN_W-1:0]   src_rem   [STEPS];
   logic [IN_W-1:0]   src_root  [STEPS];
   logic [SIDE_W-1:0] src_side  [STEPS];
   logic [IN_W-1:0]   rem_in    [STEPS];
   logic [IN_W-1:0]   root_in   [STEPS];

   always_comb begin
      logic [IN_W-1:0] bitv;
      logic [IN_W-1:0] trial;
      src_valid[0] = in_valid;
      src_rem[0]   = in_radicand;
      src_root[0]  = '0;
      src_side[0]  = in_side;
      for (int k = 1; k < STEPS; k++) begin
         src_valid[k] = valid_ff[k-1];
         src_rem[k]   = rem_ff[k-1];
         src_root[k]  = root_ff[k-1];
         src_side[k]  = side_ff[k-1];
      end
      for (int k = 0; k < STEPS; k++) begin
         bitv  = ROOT_ONE << (IN_W - 2 - 2 * k);
         trial = src_root[k] + bitv;
         if (src_rem[k] >= trial) begin
            rem_in[k]  = src_rem[k] - trial;
            root_in[k] = (src_root[k] >> 1) + bitv;
         end else begin
            rem_in[k]  = src_rem[k];
            root_in[k] = src_root[k] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STEPS; k++) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= src_valid[k];
         end
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
         side_ff[k] <= src_side[k];
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_root  = root_ff[STEPS-1][IN_W/2-1:0];
   assign out_side  = side_ff[STEPS-1];

endmodule

`default_nettype wire

// ----- hdl/scr_div_pipe.sv -----
// Pipelined restoring divider, several lanes, one quotient bit per stage.
// Depends on scr_pkg for default widths; side data travels with each beat.
`default_nettype none

module scr_div_pipe #(
   parameter int unsigned LANES  = scr_pkg::DIV_LANES,
   parameter int unsigned NUM_W  = scr_pkg::NUM_W,
   parameter int unsigned DEN_W  = scr_pkg::DEN_W,
   parameter int unsigned QUO_W  = scr_pkg::QUO_W,
   parameter int unsigned SIDE_W = 1
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   input  wire logic [LANES-1:0][NUM_W-1:0] in_num,
   input  wire logic [LANES-1:0][DEN_W-1:0] in_den,
   input  wire logic [SIDE_W-1:0]           in_side,
   output logic                             out_valid,
   output logic [LANES-1:0][QUO_W-1:0]      out_quo,
   output logic [SIDE_W-1:0]                out_side
);

   logic                        valid_ff [QUO_W];
   logic [LANES-1:0][DEN_W-1:0] rem_ff   [QUO_W];
   logic [LANES-1:0][QUO_W-1:0] acc_ff   [QUO_W];
   logic [LANES-1:0][DEN_W-1:0] den_ff   [QUO_W];
   logic [SIDE_W-1:0]           side_ff  [QUO_W];

   logic                        src_valid [QUO_W];
   logic [LANES-1:0][DEN_W-1:0] src_rem   [QUO_W];
   logic [LANES-1:0][QUO_W-1:0] src_acc   [QUO_W];
   logic [LANES-1:0][DEN_W-1:0] src_den   [QUO_W];
   logic [SIDE_W-1:0]           src_side  [QUO_W];
   logic [LANES-1:0][DEN_W-1:0] rem_in    [QUO_W];
   logic [LANES-1:0][QUO_W-1:0] acc_in    [QUO_W];

   always_comb begin
      logic [DEN_W:0] trial;
      src_valid[0] = in_valid;
      src_den[0]   = in_den;
      src_side[0]  = in_side;
      for (int l = 0; l < LANES; l++) begin
         src_rem[0][l] = DEN_W'(in_num[l] >> QUO_W);
         src_acc[0][l] = in_num[l][QUO_W-1:0];
      end
      for (int k = 1; k < QUO_W; k++) begin
         src_valid[k] = valid_ff[k-1];
         src_rem[k]   = rem_ff[k-1];
         src_acc[k]   = acc_ff[k-1];
         src_den[k]   = den_ff[k-1];
         src_side[k]  = side_ff[k-1];
      end
      for (int k = 0; k < QUO_W; k++) begin
         for (int l = 0; l < LANES; l++) begin
            trial = {src_rem[k][l], src_acc[k][l][QUO_W-1]};
            if (trial >= {1'b0, src_den[k][l]}) begin
               rem_in[k][l] = DEN_W'(trial - {1'b0, src_den[k][l]});
               acc_in[k][l] = {src_acc[k][l][QUO_W-2:0], 1'b1};
            end else begin
               rem_in[k][l] = trial[DEN_W-1:0];
               acc_in[k][l] = {src_acc[k][l][QUO_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QUO_W; k++) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= src_valid[k];
         end
         rem_ff[k]  <= rem_in[k];
         acc_ff[k]  <= acc_in[k];
         den_ff[k]  <= src_den[k];
         side_ff[k] <= src_side[k];
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign out_quo   = acc_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

`default_nettype wire

// ----- hdl/scr_impulse.sv -----
// Impulse back end: projection, mass scaling, per-axis delta and saturation.
// Depends on scr_pkg; fed by the divider with unit axis and mass factors.
`default_nettype none

module scr_impulse (
   input  wire logic                                             clock,
   input  wire logic                                             reset,
   input  wire logic                                             in_valid,
   input  wire scr_pkg::scr_base_type                            in_base,
   input  wire logic [scr_pkg::AXES-1:0][scr_pkg::UM_W-1:0]      in_unit,
   input  wire logic [scr_pkg::QUO_W-1:0]                        in_fa,
   input  wire logic [scr_pkg::QUO_W-1:0]                        in_fb,
   output logic                                                  rsp_valid,
   output scr_pkg::scr_rsp_type                                  rsp_data
);

   localparam int unsigned AXES    = scr_pkg::AXES;
   localparam int unsigned WORD_W  = scr_pkg::WORD_W;
   localparam int unsigned UM_W    = scr_pkg::UM_W;
   localparam int unsigned QUO_W   = scr_pkg::QUO_W;
   localparam int unsigned PROD_W  = scr_pkg::PROD_W;
   localparam int unsigned DM_W    = scr_pkg::DM_W;
   localparam int unsigned SPLIT_D = DM_W / 2;
   localparam int unsigned PH_W    = (DM_W - SPLIT_D) + QUO_W;
   localparam int unsigned PL_W    = SPLIT_D + QUO_W;
   localparam int unsigned SUM_W   = PH_W + SPLIT_D;
   localparam int unsigned TA_W    = SUM_W - scr_pkg::T_SHIFT;
   localparam int unsigned SPLIT_T = TA_W / 2;
   localparam int unsigned QH_W    = (TA_W - SPLIT_T) + UM_W;
   localparam int unsigned QL_W    = SPLIT_T + UM_W;
   localparam int unsigned QS_W    = QH_W + SPLIT_T;
   localparam int unsigned DA_W    = QS_W - scr_pkg::D_SHIFT;
   localparam int unsigned RES_W   = DA_W + 2;

   function automatic logic [WORD_W-1:0] sat_word(input logic signed [RES_W-1:0] v);
      if (&v[RES_W-1:WORD_W-1] || ~|v[RES_W-1:WORD_W-1]) begin
         return v[WORD_W-1:0];
      end else if (v[RES_W-1]) begin
         return {1'b1, {(WORD_W-1){1'b0}}};
      end else begin
         return {1'b0, {(WORD_W-1){1'b1}}};
      end
   endfunction

   // project relative velocity on the signed unit axis
   logic                                v1_ff;
   scr_pkg::scr_base_type               base1_ff;
   logic [AXES-1:0][UM_W-1:0]           unit1_ff;
   logic [QUO_W-1:0]                    fa1_ff, fb1_ff;
   logic signed [PROD_W-1:0]            prod1_ff [AXES];
   logic signed [PROD_W-1:0]            prod1_in [AXES];

   always_comb begin
      logic signed [UM_W:0] u_s;
      for (int i = 0; i < AXES; i++) begin
         u_s = in_base.cneg[i] ? -$signed({1'b0, in_unit[i]}) : $signed({1'b0, in_unit[i]});
         prod1_in[i] = $signed(in_base.diff[i]) * u_s;
      end
   end

   // sum the projection
   logic                                v2_ff;
   scr_pkg::scr_base_type               base2_ff;
   logic [AXES-1:0][UM_W-1:0]           unit2_ff;
   logic [QUO_W-1:0]                    fa2_ff, fb2_ff;
   logic signed [PROD_W-1:0]            d2_ff;

   // magnitude and sign of the projection
   logic                                v3_ff;
   scr_pkg::scr_base_type               base3_ff;
   logic [AXES-1:0][UM_W-1:0]           unit3_ff;
   logic [QUO_W-1:0]                    fa3_ff, fb3_ff;
   logic                                dneg3_ff;
   logic [DM_W-1:0]                     dm3_ff;
   logic signed [PROD_W-1:0]            dmag;

   assign dmag = d2_ff[PROD_W-1] ? -d2_ff : d2_ff;

   // partial products of |D| with each mass factor
   logic                                v4_ff;
   scr_pkg::scr_base_type               base4_ff;
   logic [AXES-1:0][UM_W-1:0]           unit4_ff;
   logic                                dneg4_ff;
   logic [PH_W-1:0]                     pah4_ff, pbh4_ff;
   logic [PL_W-1:0]                     pal4_ff, pbl4_ff;

   // scalar per body
   logic                                v5_ff;
   scr_pkg::scr_base_type               base5_ff;
   logic [AXES-1:0][UM_W-1:0]           unit5_ff;
   logic                                dneg5_ff;
   logic [TA_W-1:0]                     ta5_ff, tb5_ff;
   logic [SUM_W-1:0]                    suma, sumb;

   assign suma = {pah4_ff, {SPLIT_D{1'b0}}} + SUM_W'(pal4_ff);
   assign sumb = {pbh4_ff, {SPLIT_D{1'b0}}} + SUM_W'(pbl4_ff);

   // partial products of the scalars with each axis
   logic                                v6_ff;
   scr_pkg::scr_base_type               base6_ff;
   logic                                dneg6_ff;
   logic [QH_W-1:0]                     qah6_ff [AXES];
   logic [QL_W-1:0]                     qal6_ff [AXES];
   logic [QH_W-1:0]                     qbh6_ff [AXES];
   logic [QL_W-1:0]                     qbl6_ff [AXES];

   // per-axis deltas
   logic                                v7_ff;
   scr_pkg::scr_base_type               base7_ff;
   logic                                dneg7_ff;
   logic [DA_W-1:0]                     da7_ff [AXES];
   logic [DA_W-1:0]                     db7_ff [AXES];
   logic [QS_W-1:0]                     qsa [AXES];
   logic [QS_W-1:0]                     qsb [AXES];

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         qsa[i] = {qah6_ff[i], {SPLIT_T{1'b0}}} + QS_W'(qal6_ff[i]);
         qsb[i] = {qbh6_ff[i], {SPLIT_T{1'b0}}} + QS_W'(qbl6_ff[i]);
      end
   end

   // apply, saturate, or pass through
   logic                                rsp_valid_ff;
   scr_pkg::scr_rsp_type                rsp_data_ff;
   scr_pkg::scr_rsp_type                rsp_data_in;

   always_comb begin
      logic signed [RES_W-1:0] va_x, vb_x, da_x, db_x;
      logic [WORD_W-1:0]       ra [AXES];
      logic [WORD_W-1:0]       rb [AXES];
      for (int i = 0; i < AXES; i++) begin
         va_x = RES_W'($signed(base7_ff.va[i]));
         vb_x = RES_W'($signed(base7_ff.vb[i]));
         da_x = $signed(RES_W'(da7_ff[i]));
         db_x = $signed(RES_W'(db7_ff[i]));
         if (!base7_ff.apply) begin
            ra[i] = base7_ff.va[i];
            rb[i] = base7_ff.vb[i];
         end else if (dneg7_ff ^ base7_ff.cneg[i]) begin
            ra[i] = sat_word(va_x + da_x);
            rb[i] = sat_word(vb_x - db_x);
         end else begin
            ra[i] = sat_word(va_x - da_x);
            rb[i] = sat_word(vb_x + db_x);
         end
      end
      rsp_data_in.new_vel_a_x      = ra[0];
      rsp_data_in.new_vel_a_y      = ra[1];
      rsp_data_in.new_vel_a_z      = ra[2];
      rsp_data_in.new_vel_b_x      = rb[0];
      rsp_data_in.new_vel_b_y      = rb[1];
      rsp_data_in.new_vel_b_z      = rb[2];
      rsp_data_in.responded        = base7_ff.apply;
      rsp_data_in.degenerate       = base7_ff.degen;
      rsp_data_in.notice_a_trigger = base7_ff.notice_a;
      rsp_data_in.notice_b_trigger = base7_ff.notice_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= in_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         v7_ff        <= v6_ff;
         rsp_valid_ff <= v7_ff;
      end

      base1_ff <= in_base;
      unit1_ff <= in_unit;
      fa1_ff   <= in_fa;
      fb1_ff   <= in_fb;
      for (int i = 0; i < AXES; i++) begin
         prod1_ff[i] <= prod1_in[i];
      end

      base2_ff <= base1_ff;
      unit2_ff <= unit1_ff;
      fa2_ff   <= fa1_ff;
      fb2_ff   <= fb1_ff;
      d2_ff    <= prod1_ff[0] + prod1_ff[1] + prod1_ff[2];

      base3_ff <= base2_ff;
      unit3_ff <= unit2_ff;
      fa3_ff   <= fa2_ff;
      fb3_ff   <= fb2_ff;
      dneg3_ff <= d2_ff[PROD_W-1];
      dm3_ff   <= dmag[DM_W-1:0];

      base4_ff <= base3_ff;
      unit4_ff <= unit3_ff;
      dneg4_ff <= dneg3_ff;
      pah4_ff  <= PH_W'(dm3_ff[DM_W-1:SPLIT_D]) * PH_W'(fa3_ff);
      pal4_ff  <= PL_W'(dm3_ff[SPLIT_D-1:0]) * PL_W'(fa3_ff);
      pbh4_ff  <= PH_W'(dm3_ff[DM_W-1:SPLIT_D]) * PH_W'(fb3_ff);
      pbl4_ff  <= PL_W'(dm3_ff[SPLIT_D-1:0]) * PL_W'(fb3_ff);

      base5_ff <= base4_ff;
      unit5_ff <= unit4_ff;
      dneg5_ff <= dneg4_ff;
      ta5_ff   <= suma[SUM_W-1:scr_pkg::T_SHIFT];
      tb5_ff   <= sumb[SUM_W-1:scr_pkg::T_SHIFT];

      base6_ff <= base5_ff;
      dneg6_ff <= dneg5_ff;
      for (int i = 0; i < AXES; i++) begin
         qah6_ff[i] <= QH_W'(ta5_ff[TA_W-1:SPLIT_T]) * QH_W'(unit5_ff[i]);
         qal6_ff[i] <= QL_W'(ta5_ff[SPLIT_T-1:0]) * QL_W'(unit5_ff[i]);
         qbh6_ff[i] <= QH_W'(tb5_ff[TA_W-1:SPLIT_T]) * QH_W'(unit5_ff[i]);
         qbl6_ff[i] <= QL_W'(tb5_ff[SPLIT_T-1:0]) * QL_W'(unit5_ff[i]);
      end

      base7_ff <= base6_ff;
      dneg7_ff <= dneg6_ff;
      for (int i = 0; i < AXES; i++) begin
         da7_ff[i] <= qsa[i][QS_W-1:scr_pkg::D_SHIFT];
         db7_ff[i] <= qsb[i][QS_W-1:scr_pkg::D_SHIFT];
      end

      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- hdl/sphere_collision_response_unit.sv -----
// Sphere collision response: top level with input capture, axis scaling and squares.
// Depends on scr_pkg, scr_sqrt_pipe, scr_div_pipe and scr_impulse.
//
// Takes one colliding pair per clock whenever busy is low (busy is high only during
// reset) and returns exactly one result per pair, in order, as a one-cycle beat on
// rsp_valid that cannot be held off. Its pipeline is the 32-stage square root of the
// offset length and the 30-stage divider that forms the unit axis and both mass
// factors, with five stages in front and eight behind. The restitution register is
// written through the csr channel (ready whenever reset is low) and must only change
// while no pair is in flight.
`default_nettype none

module sphere_collision_response_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire scr_pkg::scr_req_type           req_data,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [scr_pkg::CSR_W-1:0]      csr_data,
   output logic                                rsp_valid,
   output scr_pkg::scr_rsp_type                rsp_data
);

   localparam int unsigned AXES   = scr_pkg::AXES;
   localparam int unsigned WORD_W = scr_pkg::WORD_W;

   assign busy      = reset;
   assign csr_ready = !reset;

   logic [scr_pkg::CSR_W-1:0] restitution_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         restitution_ff <= scr_pkg::RESTITUTION_RESET;
      end else if (csr_valid && csr_ready) begin
         restitution_ff <= csr_data;
      end
   end

   // capture
   logic                 v0_ff;
   scr_pkg::scr_req_type in_ff;

   // decode, magnitudes, totals
   logic                              v1_ff;
   scr_pkg::scr_base_type             base1_ff, base1_in;
   logic [AXES-1:0][WORD_W-1:0]       abs1_ff, abs1_in;
   logic [WORD_W-1:0]                 max1_ff, max1_in;
   logic [scr_pkg::DEN_W-1:0]         total1_ff, total1_in;
   logic [scr_pkg::KM_W-1:0]          kma1_ff, kma1_in, kmb1_ff, kmb1_in;

   always_comb begin
      logic [WORD_W-1:0]            va_s [AXES];
      logic [WORD_W-1:0]            vb_s [AXES];
      logic [WORD_W-1:0]            off  [AXES];
      logic [scr_pkg::FACTOR_W-1:0] factor;
      va_s[0] = in_ff.vel_a_x;
      va_s[1] = in_ff.vel_a_y;
      va_s[2] = in_ff.vel_a_z;
      vb_s[0] = in_ff.vel_b_x;
      vb_s[1] = in_ff.vel_b_y;
      vb_s[2] = in_ff.vel_b_z;
      off[0]  = in_ff.offset_x;
      off[1]  = in_ff.offset_y;
      off[2]  = in_ff.offset_z;
      for (int i = 0; i < AXES; i++) begin
         abs1_in[i]       = off[i][WORD_W-1] ? (~off[i] + 1'b1) : off[i];
         base1_in.va[i]   = va_s[i];
         base1_in.vb[i]   = vb_s[i];
         base1_in.diff[i] = {va_s[i][WORD_W-1], va_s[i]} - {vb_s[i][WORD_W-1], vb_s[i]};
         base1_in.cneg[i] = off[i][WORD_W-1];
      end
      max1_in = (abs1_in[0] > abs1_in[1]) ? abs1_in[0] : abs1_in[1];
      if (abs1_in[2] > max1_in) begin
         max1_in = abs1_in[2];
      end
      total1_in = {1'b0, in_ff.mass_a} + {1'b0, in_ff.mass_b};
      factor    = scr_pkg::ONE_Q15 + {1'b0, restitution_ff};
      kma1_in   = scr_pkg::KM_W'(factor) * scr_pkg::KM_W'(in_ff.mass_b);
      kmb1_in   = scr_pkg::KM_W'(factor) * scr_pkg::KM_W'(in_ff.mass_a);
      base1_in.degen    = (max1_in == '0) || (total1_in == '0);
      base1_in.apply    = !base1_in.degen
                          && !in_ff.pair_flags[scr_pkg::FLAG_TRIG_A]
                          && !in_ff.pair_flags[scr_pkg::FLAG_TRIG_B]
                          && in_ff.pair_flags[scr_pkg::FLAG_OVL_A]
                          && in_ff.pair_flags[scr_pkg::FLAG_OVL_B];
      base1_in.notice_a = in_ff.pair_flags[scr_pkg::FLAG_TRIG_B];
      base1_in.notice_b = in_ff.pair_flags[scr_pkg::FLAG_TRIG_A];
   end

   // scale the axis so its largest component sits in [2^30, 2^31]
   logic                        v2_ff;
   scr_pkg::scr_root_side_type  side2_ff, side2_in;

   always_comb begin
      logic [WORD_W-1:0]           norm_max;
      logic [AXES-1:0][WORD_W-1:0] norm_c;
      norm_max = max1_ff;
      norm_c   = abs1_ff;
      for (int s = scr_pkg::NORM_STEPS - 1; s >= 0; s--) begin
         if ((norm_max >> (WORD_W - 1 - (1 << s))) == '0) begin
            norm_max = norm_max << (1 << s);
            for (int i = 0; i < AXES; i++) begin
               norm_c[i] = norm_c[i] << (1 << s);
            end
         end
      end
      side2_in.base  = base1_ff;
      side2_in.cms   = norm_c;
      side2_in.total = total1_ff;
      side2_in.km_a  = kma1_ff;
      side2_in.km_b  = kmb1_ff;
   end

   // squares
   logic                                  v3_ff;
   scr_pkg::scr_root_side_type            side3_ff;
   logic [AXES-1:0][scr_pkg::ROOT_IN_W-1:0] sq3_ff;

   // sum of squares
   logic                                  v4_ff;
   scr_pkg::scr_root_side_type            side4_ff;
   logic [scr_pkg::ROOT_IN_W-1:0]         n2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v0_ff <= start && !busy;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      in_ff     <= req_data;
      base1_ff  <= base1_in;
      abs1_ff   <= abs1_in;
      max1_ff   <= max1_in;
      total1_ff <= total1_in;
      kma1_ff   <= kma1_in;
      kmb1_ff   <= kmb1_in;
      side2_ff  <= side2_in;
      side3_ff  <= side2_ff;
      for (int i = 0; i < AXES; i++) begin
         sq3_ff[i] <= scr_pkg::ROOT_IN_W'(side2_ff.cms[i])
                      * scr_pkg::ROOT_IN_W'(side2_ff.cms[i]);
      end
      side4_ff  <= side3_ff;
      n2_ff     <= sq3_ff[0] + sq3_ff[1] + sq3_ff[2];
   end

   // length
   logic                       root_valid;
   logic [WORD_W-1:0]          root_len;
   scr_pkg::scr_root_side_type root_side;

   scr_sqrt_pipe #(
      .IN_W   (scr_pkg::ROOT_IN_W),
      .SIDE_W ($bits(scr_pkg::scr_root_side_type))
   ) u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (v4_ff),
      .in_radicand (n2_ff),
      .in_side     (side4_ff),
      .out_valid   (root_valid),
      .out_root    (root_len),
      .out_side    (root_side)
   );

   // unit axis and both mass factors
   logic [scr_pkg::DIV_LANES-1:0][scr_pkg::NUM_W-1:0] div_num;
   logic [scr_pkg::DIV_LANES-1:0][scr_pkg::DEN_W-1:0] div_den;
   logic [scr_pkg::DIV_LANES-1:0][scr_pkg::QUO_W-1:0] div_quo;
   logic                                              div_valid;
   scr_pkg::scr_base_type                             div_side;
   logic [AXES-1:0][scr_pkg::UM_W-1:0]                unit;

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         div_num[i] = scr_pkg::NUM_W'({root_side.cms[i], {scr_pkg::UNIT_FRAC{1'b0}}});
         div_den[i] = scr_pkg::DEN_W'(root_len);
         unit[i]    = div_quo[i][scr_pkg::UM_W-1:0];
      end
      div_num[scr_pkg::LANE_FA] = {root_side.km_a, {scr_pkg::FACT_SHIFT{1'b0}}};
      div_den[scr_pkg::LANE_FA] = root_side.total;
      div_num[scr_pkg::LANE_FB] = {root_side.km_b, {scr_pkg::FACT_SHIFT{1'b0}}};
      div_den[scr_pkg::LANE_FB] = root_side.total;
   end

   scr_div_pipe #(
      .LANES  (scr_pkg::DIV_LANES),
      .NUM_W  (scr_pkg::NUM_W),
      .DEN_W  (scr_pkg::DEN_W),
      .QUO_W  (scr_pkg::QUO_W),
      .SIDE_W ($bits(scr_pkg::scr_base_type))
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (root_valid),
      .in_num    (div_num),
      .in_den    (div_den),
      .in_side   (root_side.base),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_side  (div_side)
   );

   scr_impulse u_impulse (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_base   (div_side),
      .in_unit   (unit),
      .in_fa     (div_quo[scr_pkg::LANE_FA]),
      .in_fb     (div_quo[scr_pkg::LANE_FB]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking bench for sphere_collision_response_unit: directed table plus random pairs.
// Depends on scr_pkg and the unit; expected responses come from a local impulse predictor or typed pass-through rows.
`timescale 1ns / 100ps

module tb_top;

   typedef struct {
      scr_pkg::scr_req_type req;
      bit                   typed;
      scr_pkg::scr_rsp_type rsp;
   } pair_row_type;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned FLUSH_CYCLES = 100;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   scr_pkg::scr_req_type      req_data;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [scr_pkg::CSR_W-1:0] csr_data;
   logic                      rsp_valid;
   scr_pkg::scr_rsp_type      rsp_data;

   scr_pkg::scr_rsp_type      expected_rsp_q[$];
   scr_pkg::scr_rsp_type      typed_rsp_q[$];
   bit                        typed_flag_q[$];
   pair_row_type              pair_table[$];
   logic [scr_pkg::CSR_W-1:0] restitution_q;
   int unsigned               mismatches;
   int unsigned               cycles;
   int unsigned               pairs_sent;
   int unsigned               responses_seen;
   int unsigned               responded_seen;

   sphere_collision_response_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root;
      longint unsigned probe;
      root = 0;
      probe = 64'd1 << 62;
      while (probe > n) probe >>= 2;
      while (probe != 0) begin
         if (n >= root + probe) begin
            n -= root + probe;
            root = (root >> 1) + probe;
         end else begin
            root >>= 1;
         end
         probe >>= 2;
      end
      return root;
   endfunction

   function automatic longint clamp_word(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic scr_pkg::scr_rsp_type predict_impulse(scr_pkg::scr_req_type r,
                                                            logic [scr_pkg::CSR_W-1:0] rest);
      longint               va[3];
      longint               vb[3];
      longint               off[3];
      longint               res[6];
      longint unsigned      cm[3];
      longint unsigned      um[3];
      bit                   cneg[3];
      longint unsigned      total;
      longint unsigned      maxm;
      longint unsigned      n2;
      longint unsigned      len;
      longint unsigned      fa;
      longint unsigned      fb;
      longint unsigned      dm;
      longint unsigned      ta;
      longint unsigned      tb;
      longint               dot;
      longint               da;
      longint               db;
      logic [127:0]         prod;
      bit                   solid;
      bit                   overlap;
      bit                   degen;
      bit                   dneg;
      scr_pkg::scr_rsp_type o;
      va[0] = $signed(r.vel_a_x);  va[1] = $signed(r.vel_a_y);  va[2] = $signed(r.vel_a_z);
      vb[0] = $signed(r.vel_b_x);  vb[1] = $signed(r.vel_b_y);  vb[2] = $signed(r.vel_b_z);
      off[0] = $signed(r.offset_x); off[1] = $signed(r.offset_y); off[2] = $signed(r.offset_z);
      total = 64'(r.mass_a) + 64'(r.mass_b);
      maxm = 0;
      for (int i = 0; i < 3; i++) begin
         cneg[i] = off[i] < 0;
         cm[i] = cneg[i] ? longint'(-off[i]) : longint'(off[i]);
         if (cm[i] > maxm) maxm = cm[i];
         res[i] = va[i];
         res[3 + i] = vb[i];
      end
      solid = (r.pair_flags[scr_pkg::FLAG_TRIG_A] == 1'b0)
              && (r.pair_flags[scr_pkg::FLAG_TRIG_B] == 1'b0);
      overlap = r.pair_flags[scr_pkg::FLAG_OVL_A] && r.pair_flags[scr_pkg::FLAG_OVL_B];
      degen = (maxm == 0) || (total == 0);
      o.responded = 1'b0;
      if (!degen && solid && overlap) begin
         while (maxm < (64'd1 << 30)) begin
            maxm <<= 1;
            for (int i = 0; i < 3; i++) cm[i] <<= 1;
         end
         n2 = 0;
         for (int i = 0; i < 3; i++) n2 += cm[i] * cm[i];
         len = int_sqrt(n2);
         dot = 0;
         for (int i = 0; i < 3; i++) begin
            um[i] = (cm[i] << 28) / len;
            dot += (va[i] - vb[i]) * (cneg[i] ? -longint'(um[i]) : longint'(um[i]));
         end
         dneg = dot < 0;
         dm = dneg ? longint'(-dot) : longint'(dot);
         fa = ((64'd32768 + 64'(rest)) * 64'(r.mass_b) << 13) / total;
         fb = ((64'd32768 + 64'(rest)) * 64'(r.mass_a) << 13) / total;
         prod = {64'd0, dm} * {64'd0, fa};
         ta = prod[103:40];
         prod = {64'd0, dm} * {64'd0, fb};
         tb = prod[103:40];
         for (int i = 0; i < 3; i++) begin
            prod = {64'd0, ta} * {64'd0, um[i]};
            da = prod[107:44];
            prod = {64'd0, tb} * {64'd0, um[i]};
            db = prod[107:44];
            if (dneg != cneg[i]) begin
               da = -da;
               db = -db;
            end
            res[i] = clamp_word(va[i] - da);
            res[3 + i] = clamp_word(vb[i] + db);
         end
         o.responded = 1'b1;
      end
      o.new_vel_a_x = res[0][31:0];
      o.new_vel_a_y = res[1][31:0];
      o.new_vel_a_z = res[2][31:0];
      o.new_vel_b_x = res[3][31:0];
      o.new_vel_b_y = res[4][31:0];
      o.new_vel_b_z = res[5][31:0];
      o.degenerate = degen;
      o.notice_a_trigger = r.pair_flags[scr_pkg::FLAG_TRIG_B];
      o.notice_b_trigger = r.pair_flags[scr_pkg::FLAG_TRIG_A];
      return o;
   endfunction

   function automatic scr_pkg::scr_req_type make_pair(logic [31:0] ma, logic [31:0] mb,
                                                      logic [31:0] vax, logic [31:0] vay,
                                                      logic [31:0] vaz, logic [31:0] vbx,
                                                      logic [31:0] vby, logic [31:0] vbz,
                                                      logic [31:0] ox, logic [31:0] oy,
                                                      logic [31:0] oz, logic [3:0] fl);
      scr_pkg::scr_req_type r;
      r.mass_a = ma;     r.mass_b = mb;
      r.vel_a_x = vax;   r.vel_a_y = vay;   r.vel_a_z = vaz;
      r.vel_b_x = vbx;   r.vel_b_y = vby;   r.vel_b_z = vbz;
      r.offset_x = ox;   r.offset_y = oy;   r.offset_z = oz;
      r.pair_flags = fl;
      return r;
   endfunction

   function automatic scr_pkg::scr_rsp_type pass_through(scr_pkg::scr_req_type r, bit degen);
      scr_pkg::scr_rsp_type o;
      o.new_vel_a_x = r.vel_a_x; o.new_vel_a_y = r.vel_a_y; o.new_vel_a_z = r.vel_a_z;
      o.new_vel_b_x = r.vel_b_x; o.new_vel_b_y = r.vel_b_y; o.new_vel_b_z = r.vel_b_z;
      o.responded = 1'b0;
      o.degenerate = degen;
      o.notice_a_trigger = r.pair_flags[scr_pkg::FLAG_TRIG_B];
      o.notice_b_trigger = r.pair_flags[scr_pkg::FLAG_TRIG_A];
      return o;
   endfunction

   function automatic logic [31:0] random_word();
      logic [31:0] w;
      case ($urandom_range(0, 6))
         0: w = $urandom;
         1: w = 32'h8000_0000;
         2: w = 32'h7FFF_FFFF;
         3: w = 32'h0;
         4: w = $urandom_range(0, 1 << 20);
         default: w = $urandom >> $urandom_range(4, 16);
      endcase
      if ($urandom_range(0, 1) && w != 32'h8000_0000) w = -w;
      return w;
   endfunction

   function automatic logic [31:0] random_mass();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'hFFFF_FFFF;
         2: return 32'h0;
         default: return $urandom >> $urandom_range(4, 20);
      endcase
   endfunction

   function automatic scr_pkg::scr_req_type random_pair();
      logic [3:0] fl;
      fl = ($urandom_range(0, 99) < 85) ? 4'b0011 : 4'($urandom);
      return make_pair(random_mass(), random_mass(), random_word(), random_word(),
                       random_word(), random_word(), random_word(), random_word(),
                       random_word(), random_word(), random_word(), fl);
   endfunction

   task automatic send_pair(scr_pkg::scr_req_type r, bit typed, scr_pkg::scr_rsp_type rsp);
      @(negedge clock);
      typed_flag_q.push_back(typed);
      typed_rsp_q.push_back(rsp);
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      pairs_sent++;
   endtask

   task automatic hold_off(int unsigned n);
      @(negedge clock);
      start <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic write_restitution(logic [scr_pkg::CSR_W-1:0] v);
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      restitution_q = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(int unsigned count);
      int unsigned          burst;
      scr_pkg::scr_rsp_type none;
      none = '0;
      burst = $urandom_range(1, 20);
      for (int unsigned k = 0; k < count; k++) begin
         send_pair(random_pair(), 1'b0, none);
         if (--burst == 0) begin
            if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 6));
            burst = $urandom_range(1, 30);
         end
      end
      hold_off(1);
   endtask

   always @(posedge clock) begin
      scr_pkg::scr_rsp_type want;
      scr_pkg::scr_rsp_type typed_rsp;
      bit                   typed;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb_top: FAIL");
         $finish;
      end
      if (!reset && rsp_valid) begin
         responses_seen++;
         if (expected_rsp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat: %p", rsp_data);
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_data.responded) responded_seen++;
            if (rsp_data !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at cycle %0d\n  exp %p\n  got %p", cycles, want, rsp_data);
            end
         end
      end
      if (!reset && start && !busy) begin
         typed = typed_flag_q.pop_front();
         typed_rsp = typed_rsp_q.pop_front();
         expected_rsp_q.push_back(typed ? typed_rsp : predict_impulse(req_data, restitution_q));
      end
   end

   initial begin
      scr_pkg::scr_req_type      r;
      pair_row_type              row;
      logic [scr_pkg::CSR_W-1:0] settings[5];
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      restitution_q = scr_pkg::RESTITUTION_RESET;
      mismatches = 0;
      cycles = 0;
      pairs_sent = 0;
      responses_seen = 0;
      responded_seen = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      r = '0;
      r.pair_flags = 4'b0011;
      row = '{r, 1'b1, pass_through(r, 1'b1)};                        pair_table.push_back(row);
      r = make_pair('1, '1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h8000_0000,
                    32'h7FFF_FFFF, '1, 0, 0, 0, 4'b0011);
      row = '{r, 1'b1, pass_through(r, 1'b1)};                        pair_table.push_back(row);
      r = make_pair(0, 0, 32'h10000, 0, 0, 32'hFFFF0000, 0, 0, 32'h10000, 0, 0, 4'b0011);
      row = '{r, 1'b1, pass_through(r, 1'b1)};                        pair_table.push_back(row);
      r.offset_x = 0; r.pair_flags = 4'b1111;
      row = '{r, 1'b1, pass_through(r, 1'b1)};                        pair_table.push_back(row);
      r = make_pair(32'h10000, 32'h10000, 32'h10000, 0, 0, 32'hFFFF0000, 0, 0,
                    32'h10000, 0, 0, 4'b0111);
      row = '{r, 1'b1, pass_through(r, 1'b0)};                        pair_table.push_back(row);
      r.pair_flags = 4'b1011;
      row = '{r, 1'b1, pass_through(r, 1'b0)};                        pair_table.push_back(row);
      r.pair_flags = 4'b0001;
      row = '{r, 1'b1, pass_through(r, 1'b0)};                        pair_table.push_back(row);
      r.pair_flags = 4'b0010;
      row = '{r, 1'b1, pass_through(r, 1'b0)};                        pair_table.push_back(row);
      r.pair_flags = 4'b0000;
      row = '{r, 1'b1, pass_through(r, 1'b0)};                        pair_table.push_back(row);
      r.pair_flags = 4'b0011;
      row = '{r, 1'b0, '0};                                           pair_table.push_back(row);
      r = make_pair('1, '1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 4'b0011);
      row = '{r, 1'b0, '0};                                           pair_table.push_back(row);
      r = make_pair('1, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF,
                    32'h8000_0000, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 4'b0011);
      row = '{r, 1'b0, '0};                                           pair_table.push_back(row);
      r = make_pair(32'h1, '1, 32'h20000, 32'hFFFE0000, 32'h30000, 0, 0, 0,
                    32'h1, 32'h1, 32'h1, 4'b0011);
      row = '{r, 1'b0, '0};                                           pair_table.push_back(row);
      r = make_pair(0, 32'h8000, 32'h12345, 32'h0, 32'hFFFF0000, 32'h50000, 32'h1, 0,
                    32'hFFFFFFFF, 0, 32'h00020000, 4'b0011);
      row = '{r, 1'b0, '0};                                           pair_table.push_back(row);

      write_restitution(scr_pkg::RESTITUTION_RESET);
      foreach (pair_table[i]) send_pair(pair_table[i].req, pair_table[i].typed, pair_table[i].rsp);
      hold_off(1);

      settings = '{16'h0000, 16'hFFFF, 16'h8000, scr_pkg::CSR_W'($urandom), 16'h4000};
      foreach (settings[i]) begin
         write_restitution(settings[i]);
         foreach (pair_table[j])
            if (!pair_table[j].typed) send_pair(pair_table[j].req, 1'b0, '0);
         random_phase(180);
      end

      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (FLUSH_CYCLES) @(posedge clock);
      $display("sent %0d pairs over six restitution settings, %0d responses, %0d with impulse",
               pairs_sent, responses_seen, responded_seen);
      $display("mismatches: %0d", mismatches);
      if (mismatches == 0 && expected_rsp_q.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
